@@ src/dss_pkg.sv @@
// drum step sequencer package: payload structs, register indexes and message codes
package dss_pkg;

   // grid size defaults
   localparam int STEPS_DEFAULT = 16;
   localparam int ROWS_DEFAULT  = 8;

   // field widths
   localparam int POS_W    = 48;
   localparam int FRAC_W   = 16;
   localparam int SIG_W    = 5;
   localparam int SIDX_W   = 4;
   localparam int PAT_W    = 8;
   localparam int STEP_W   = 6;
   localparam int CHAN_W   = 4;
   localparam int NOTE_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   // command codes
   localparam logic CMD_POSITION = 1'b0;
   localparam logic CMD_GRID     = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIDI_CHANNEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_NOTE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_VELOCITY = 2'd2;

   // register reset values
   localparam logic [CHAN_W-1:0] CHANNEL_RESET  = 4'd9;
   localparam logic [NOTE_W-1:0] BASE_RESET     = 7'd32;
   localparam logic [NOTE_W-1:0] VELOCITY_RESET = 7'd90;

   // midi message codes
   localparam logic [3:0]        STATUS_CONTROL   = 4'hB;
   localparam logic [3:0]        STATUS_NOTE_ON   = 4'h9;
   localparam logic [NOTE_W-1:0] CC_ALL_NOTES_OFF = 7'd123;

   typedef struct packed {
      logic              command;
      logic [POS_W-1:0]  ppq_position;
      logic              playhead_valid;
      logic [SIG_W-1:0]  sig_numerator;
      logic [SIG_W-1:0]  sig_denominator;
      logic [SIDX_W-1:0] step_index;
      logic [PAT_W-1:0]  row_pattern;
   } req_type;

   typedef struct packed {
      logic [7:0]        status_byte;
      logic [NOTE_W-1:0] data_one;
      logic [NOTE_W-1:0] data_two;
      logic              sample_offset;
      logic              last;
   } rsp_type;

endpackage

@@ src/drum_step_sequencer.sv @@
// drum step sequencer top level: bit-serial bar and step arithmetic, grid store, midi output
// A grid write word is taken and produces nothing. A position word with an invalid
// playhead or a zero denominator is dropped without any arithmetic; a zero bar length is
// dropped once the bar length is known. Any other position word runs through one shared
// restoring divider and a shift-add multiplier, one bit per cycle: first the bar length,
// then the bar position, then the scaling multiply and then the step. When the step is the
// next one, the grid is read, then one all-notes-off word and one note-on word per set row
// go out, one per cycle while the output side keeps taking them, except that each clear
// row before the last set one is scanned without a word. The next input word is taken once
// the last output word sits in the output register. Configuration writes are always taken
// and should only be made while idle.
module drum_step_sequencer #(
   parameter int STEPS = dss_pkg::STEPS_DEFAULT,
   parameter int ROWS  = dss_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dss_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dss_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dss_pkg::CSR_DAT_W-1:0]   csr_data
);

   localparam int ROW_BITS = (ROWS < dss_pkg::PAT_W) ? ROWS : dss_pkg::PAT_W;
   localparam int ROW_W    = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;
   localparam int IDX_W    = $clog2(STEPS);
   localparam int STEP_W   = dss_pkg::STEP_W;
   localparam int NOTE_W   = dss_pkg::NOTE_W;
   localparam int SHIFT_W  = 32;
   localparam int BAR_W    = 7;
   localparam int PROD_W   = 28;
   localparam int T_W      = 14;
   localparam int CNT_W    = 6;
   localparam int REM_W    = BAR_W + dss_pkg::FRAC_W;

   localparam logic [CNT_W-1:0] BAR_STEPS = 6'd7;
   localparam logic [CNT_W-1:0] MOD_STEPS = 6'd32;
   localparam logic [CNT_W-1:0] MUL_STEPS = 6'd5;
   localparam logic [CNT_W-1:0] DIV_STEPS = 6'd14;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_BAR  = 8'b0000_0010,
      ST_MOD  = 8'b0000_0100,
      ST_MUL  = 8'b0000_1000,
      ST_DIV  = 8'b0001_0000,
      ST_LOOK = 8'b0010_0000,
      ST_OFF  = 8'b0100_0000,
      ST_SCAN = 8'b1000_0000
   } state_type;

   // grid write address, step_index reduced below STEPS
   function automatic logic [IDX_W-1:0] wr_index(input logic [dss_pkg::SIDX_W-1:0] sidx);
      logic [6:0] v;
      v = {3'b000, sidx};
      for (int k = 0; k < 3; k++) begin
         if (v >= 7'(STEPS)) begin
            v = v - 7'(STEPS);
         end
      end
      return v[IDX_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   dss_pkg::req_type        item_ff, item_in;
   logic [BAR_W-1:0]        div_rem_ff, div_rem_in;
   logic [SHIFT_W-1:0]      div_shift_ff, div_shift_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [BAR_W-1:0]        bar_ff, bar_in;
   logic [PROD_W-1:0]       acc_ff, acc_in;
   logic [STEP_W-1:0]       cur_ff, cur_in;
   logic [ROW_BITS-1:0]     pat_sr_ff, pat_sr_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   dss_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic [dss_pkg::CHAN_W-1:0] channel_ff;
   logic [NOTE_W-1:0]       base_ff;
   logic [NOTE_W-1:0]       velocity_ff;

   logic [ROW_BITS-1:0]     mem_ff [STEPS];
   logic                    entry_valid_ff [STEPS];
   logic [ROW_BITS-1:0]     rd_data_ff;
   logic                    rd_valid_ff;

   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;

   // shared divider step
   logic [BAR_W-1:0]        divisor;
   logic [BAR_W:0]          trial;
   logic [BAR_W:0]          diff;
   logic                    ge;
   logic [BAR_W-1:0]        rem_next;
   logic [SHIFT_W-1:0]      shift_next;

   // multiplier step
   logic [REM_W-1:0]        multiplicand;
   logic [PROD_W-1:0]       acc_next;

   logic [STEP_W-1:0]       step_next;
   logic [ROW_BITS-1:0]     pattern;
   logic                    out_free;
   logic                    last_iter;

   assign divisor    = state_ff[$clog2(ST_BAR)] ?
                       {{(BAR_W-dss_pkg::SIG_W){1'b0}}, item_ff.sig_denominator} : bar_ff;
   assign trial      = {div_rem_ff, div_shift_ff[SHIFT_W-1]};
   assign diff       = trial - {1'b0, divisor};
   assign ge         = (trial >= {1'b0, divisor});
   assign rem_next   = ge ? diff[BAR_W-1:0] : trial[BAR_W-1:0];
   assign shift_next = {div_shift_ff[SHIFT_W-2:0], ge};

   assign multiplicand = {div_rem_ff, item_ff.ppq_position[dss_pkg::FRAC_W-1:0]};
   assign acc_next     = {acc_ff[PROD_W-2:0], 1'b0} +
                         (div_shift_ff[SHIFT_W-1] ? PROD_W'(multiplicand) : '0);

   assign step_next = (cur_ff == STEP_W'(STEPS - 1)) ? '0 : cur_ff + 1'b1;
   assign pattern   = rd_valid_ff ? rd_data_ff : '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_iter = (cnt_ff == 6'd1);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      div_rem_in   = div_rem_ff;
      div_shift_in = div_shift_ff;
      cnt_in       = cnt_ff;
      bar_in       = bar_ff;
      acc_in       = acc_ff;
      cur_in       = cur_ff;
      pat_sr_in    = pat_sr_ff;
      row_in       = row_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_index(req_data.step_index);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               if (req_data.command == dss_pkg::CMD_GRID) begin
                  mem_we = 1'b1;
               end else if (req_data.playhead_valid && (req_data.sig_denominator != '0)) begin
                  div_rem_in   = '0;
                  div_shift_in = {req_data.sig_numerator, 2'b00, {(SHIFT_W-BAR_W){1'b0}}};
                  cnt_in       = BAR_STEPS;
                  state_in     = ST_BAR;
               end
            end
         end
         ST_BAR: begin
            div_rem_in   = rem_next;
            div_shift_in = shift_next;
            cnt_in       = cnt_ff - 1'b1;
            if (last_iter) begin
               bar_in = shift_next[BAR_W-1:0];
               if (shift_next[BAR_W-1:0] == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  div_rem_in   = '0;
                  div_shift_in = item_ff.ppq_position[dss_pkg::POS_W-1:dss_pkg::FRAC_W];
                  cnt_in       = MOD_STEPS;
                  state_in     = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            div_rem_in   = rem_next;
            div_shift_in = shift_next;
            cnt_in       = cnt_ff - 1'b1;
            if (last_iter) begin
               // remainder stays in div_rem_ff through the multiply
               acc_in       = '0;
               div_shift_in = {item_ff.sig_numerator, {(SHIFT_W-dss_pkg::SIG_W){1'b0}}};
               cnt_in       = MUL_STEPS;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in       = acc_next;
            div_shift_in = {div_shift_ff[SHIFT_W-2:0], 1'b0};
            cnt_in       = cnt_ff - 1'b1;
            if (last_iter) begin
               // 4*num*rem / 2^16 is num*rem / 2^14
               div_rem_in   = '0;
               div_shift_in = {acc_next[PROD_W-1:PROD_W-T_W], {(SHIFT_W-T_W){1'b0}}};
               cnt_in       = DIV_STEPS;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            div_rem_in   = rem_next;
            div_shift_in = shift_next;
            cnt_in       = cnt_ff - 1'b1;
            if (last_iter) begin
               if (shift_next[T_W-1:0] == T_W'(step_next)) begin
                  cur_in   = step_next;
                  state_in = ST_LOOK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LOOK: begin
            // grid read of the new step lands in rd_data_ff
            state_in = ST_OFF;
         end
         ST_OFF: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status_byte   = {dss_pkg::STATUS_CONTROL, channel_ff};
               rsp_data_in.data_one      = dss_pkg::CC_ALL_NOTES_OFF;
               rsp_data_in.data_two      = '0;
               rsp_data_in.sample_offset = 1'b0;
               rsp_data_in.last          = (pattern == '0);
               pat_sr_in                 = pattern;
               row_in                    = '0;
               state_in                  = (pattern == '0) ? ST_IDLE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pat_sr_ff[0]) begin
               if (out_free) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.status_byte   = {dss_pkg::STATUS_NOTE_ON, channel_ff};
                  rsp_data_in.data_one      = base_ff + NOTE_W'(row_ff);
                  rsp_data_in.data_two      = velocity_ff;
                  rsp_data_in.sample_offset = 1'b1;
                  rsp_data_in.last          = ((pat_sr_ff >> 1) == '0);
                  pat_sr_in                 = pat_sr_ff >> 1;
                  row_in                    = row_ff + 1'b1;
                  if ((pat_sr_ff >> 1) == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               pat_sr_in = pat_sr_ff >> 1;
               row_in    = row_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      div_rem_ff   <= div_rem_in;
      div_shift_ff <= div_shift_in;
      cnt_ff       <= cnt_in;
      bar_ff       <= bar_in;
      acc_ff       <= acc_in;
      pat_sr_ff    <= pat_sr_in;
      row_ff       <= row_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff  <= dss_pkg::CHANNEL_RESET;
         base_ff     <= dss_pkg::BASE_RESET;
         velocity_ff <= dss_pkg::VELOCITY_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            dss_pkg::CSR_MIDI_CHANNEL:  channel_ff  <= csr_data[dss_pkg::CHAN_W-1:0];
            dss_pkg::CSR_BASE_NOTE:     base_ff     <= csr_data;
            dss_pkg::CSR_NOTE_VELOCITY: velocity_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // grid entry valid bits, an unwritten step reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STEPS; k++) begin
            entry_valid_ff[k] <= 1'b0;
         end
      end else if (mem_we) begin
         entry_valid_ff[mem_waddr] <= 1'b1;
      end
   end

   // grid store with registered read at the current step
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= req_data.row_pattern[ROW_BITS-1:0];
      end
      rd_data_ff  <= mem_ff[cur_ff[IDX_W-1:0]];
      rd_valid_ff <= entry_valid_ff[cur_ff[IDX_W-1:0]];
   end

endmodule

@@ sim/drum_step_sequencer_chk.sv @@
// drum step sequencer checker: watches all three channels, predicts midi words, compares them
module drum_step_sequencer_chk (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  dss_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  dss_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [dss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dss_pkg::CSR_DAT_W-1:0]   csr_data,
   output int                              mismatch_count,
   output int                              words_due,
   output logic [dss_pkg::STEP_W-1:0]      step_now
);
   import dss_pkg::*;

   // shadow copy of the grid, playhead step and registers
   logic [PAT_W-1:0]  grid_rows [STEPS_DEFAULT];
   logic [STEP_W-1:0] play_step;
   logic [CHAN_W-1:0] channel;
   logic [NOTE_W-1:0] base_note;
   logic [NOTE_W-1:0] velocity;

   // midi words still owed by the block, oldest first
   rsp_type           due_messages [$];
   rsp_type           want;
   int                faults = 0;
   int                k;

   // works out the midi words that one accepted input word causes
   task automatic derive_messages(input req_type w);
      logic [63:0]      span, bar_len, bar_fix, bar_pos, step;
      logic [PAT_W-1:0] rows;
      int               top_row;
      int               i;
      rsp_type          msg;
      if (w.command == CMD_GRID) begin
         grid_rows[w.step_index] = w.row_pattern;
         return;
      end
      if (!w.playhead_valid || w.sig_denominator == '0)
         return;
      // bar length in quarters, then the step inside the bar, all exact integers
      span    = 64'(w.sig_numerator) << 2;
      bar_len = span / 64'(w.sig_denominator);
      if (bar_len == 0)
         return;
      bar_fix = bar_len << FRAC_W;
      bar_pos = 64'(w.ppq_position) % bar_fix;
      step    = span * bar_pos / bar_fix;
      if (step != (64'(play_step) + 1) % STEPS_DEFAULT)
         return;
      play_step = step[STEP_W-1:0];
      rows      = grid_rows[step[SIDX_W-1:0]];
      // the highest set row carries the last flag, or all-notes-off when no row is set
      top_row = -1;
      for (i = 0; i < PAT_W; i++)
         if (rows[i]) top_row = i;
      msg               = '0;
      msg.status_byte   = {STATUS_CONTROL, channel};
      msg.data_one      = CC_ALL_NOTES_OFF;
      msg.data_two      = '0;
      msg.sample_offset = 1'b0;
      msg.last          = (top_row < 0);
      due_messages.push_back(msg);
      for (i = 0; i < PAT_W; i++) begin
         if (rows[i]) begin
            msg.status_byte   = {STATUS_NOTE_ON, channel};
            msg.data_one      = base_note + NOTE_W'(i);
            msg.data_two      = velocity;
            msg.sample_offset = 1'b1;
            msg.last          = (i == top_row);
            due_messages.push_back(msg);
         end
      end
   endtask

   task automatic report(input string why, input rsp_type exp_word, input rsp_type got);
      if (faults < 10)
         $display({"%0t: %s: expected status=%h d1=%0d d2=%0d off=%b last=%b,",
                   " got status=%h d1=%0d d2=%0d off=%b last=%b"},
                  $realtime, why, exp_word.status_byte, exp_word.data_one, exp_word.data_two,
                  exp_word.sample_offset, exp_word.last, got.status_byte, got.data_one,
                  got.data_two, got.sample_offset, got.last);
      faults++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (k = 0; k < STEPS_DEFAULT; k++)
            grid_rows[k] = '0;
         play_step = '0;
         channel   = CHANNEL_RESET;
         base_note = BASE_RESET;
         velocity  = VELOCITY_RESET;
         due_messages.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIDI_CHANNEL:  channel   = csr_data[CHAN_W-1:0];
               CSR_BASE_NOTE:     base_note = csr_data[NOTE_W-1:0];
               CSR_NOTE_VELOCITY: velocity  = csr_data[NOTE_W-1:0];
               default: ;
            endcase
         end
         // input words
         if (req_valid && req_ready)
            derive_messages(req_data);
         // output words against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (due_messages.size() == 0) begin
               report("word with nothing due", '0, rsp_data);
            end else begin
               want = due_messages.pop_front();
               if (rsp_data !== want)
                  report("word mismatch", want, rsp_data);
            end
         end
      end
      step_now       <= play_step;
      words_due      <= due_messages.size();
      mismatch_count <= faults;
   end

endmodule

@@ sim/drum_step_sequencer_tb.sv @@
// drum step sequencer testbench top: clock, reset, stimulus, output pacing and verdict
module drum_step_sequencer_tb;
   import dss_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_WORDS  = 50;
   localparam int LONG_HOLD    = 250;
   localparam int HOLD_AFTER   = 60;
   localparam int REQ_W        = $bits(req_type);

   // where in the step window an aimed position lands
   localparam int AT_LOW  = 0;
   localparam int AT_HIGH = 1;
   localparam int AT_ANY  = 2;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;
   int                   mismatch_count;
   int                   words_due;
   logic [STEP_W-1:0]    step_now;
   int                   cycle_count = 0;
   int                   song_step   = 0;
   bit                   send_calm   = 1'b0;
   bit                   take_calm   = 1'b0;

   always #5 clock = ~clock;

   drum_step_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   drum_step_sequencer_chk i_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_due      (words_due),
      .step_now       (step_now)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[drum_step_sequencer] ERROR");
         $finish;
      end
   end

   // output side: random stalls, calm stretches, and one long hold to back the block up
   initial begin : receiver
      int wait_cycles;
      int taken;
      taken     = 0;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 19) == 0) take_calm = !take_calm;
         wait_cycles = take_calm ? 0 : $urandom_range(0, 6);
         if (taken == HOLD_AFTER) wait_cycles = LONG_HOLD;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   // position word that lands inside the window of the given step
   function automatic req_type aimed_position(int target, logic [SIG_W-1:0] num,
                                              logic [SIG_W-1:0] den, int spot,
                                              logic [POS_W-1:0] hint);
      req_type     w;
      logic [63:0] span, bar_fix, lo, hi, rem, bars;
      span    = 64'(num) << 2;
      bar_fix = (span / 64'(den)) << FRAC_W;
      lo      = (64'(target) * bar_fix + span - 1) / span;
      hi      = ((64'(target) + 1) * bar_fix + span - 1) / span - 1;
      case (spot)
         AT_LOW:  rem = lo;
         AT_HIGH: rem = hi;
         default: rem = lo + 64'($urandom_range(0, 32'(hi - lo)));
      endcase
      // whole bars taken from the hint, kept below the top of the position range
      bars = 64'(hint) / bar_fix;
      if (bars != 0) bars = bars - 1;
      w.command         = CMD_POSITION;
      w.ppq_position    = POS_W'(bars * bar_fix + rem);
      w.playhead_valid  = 1'b1;
      w.sig_numerator   = num;
      w.sig_denominator = den;
      w.step_index      = SIDX_W'($urandom);
      w.row_pattern     = PAT_W'($urandom);
      return w;
   endfunction

   function automatic req_type grid_word(logic [SIDX_W-1:0] step, logic [PAT_W-1:0] rows);
      req_type w;
      w             = req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      w.command     = CMD_GRID;
      w.step_index  = step;
      w.row_pattern = rows;
      return w;
   endfunction

   // sender gap; after any idle cycle the playhead is picked up from the checker
   task automatic hold_gap();
      int gap;
      if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         song_step = step_now;
      end
   endtask

   task automatic offer_word(input req_type w);
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic send_word(input req_type w);
      hold_gap();
      offer_word(w);
   endtask

   task automatic write_one(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic write_registers(input logic [CHAN_W-1:0] ch, input logic [NOTE_W-1:0] base,
                                  input logic [NOTE_W-1:0] vel);
      write_one(CSR_MIDI_CHANNEL, CSR_DAT_W'(ch));
      write_one(CSR_BASE_NOTE, base);
      write_one(CSR_NOTE_VELOCITY, vel);
      csr_valid <= 1'b0;
   endtask

   // wait until every due word has come out and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // well-formed playhead advances for half the words, plus grid writes, off-step and junk positions
   task automatic random_phase(int count);
      req_type          w;
      int               kind, target, spot;
      logic [SIG_W-1:0] num, den;
      logic [POS_W-1:0] hint;
      repeat (count) begin
         hold_gap();
         kind = $urandom_range(0, 9);
         spot = $urandom_range(0, 5);
         if (spot > AT_ANY) spot = AT_ANY;
         hint = {16'($urandom), $urandom};
         num  = SIG_W'($urandom_range(4, 31));
         if ($urandom_range(0, 3) == 0) den = SIG_W'($urandom_range(1, 31));
         else den = SIG_W'(1 << $urandom_range(0, 4));
         if ({num, 2'b00} < 7'(den)) den = 5'd16;
         if (kind < 5) begin
            target    = (song_step + 1) % STEPS_DEFAULT;
            w         = aimed_position(target, num, den, spot, hint);
            song_step = target;
         end else if (kind < 7) begin
            w = grid_word(SIDX_W'($urandom), PAT_W'($urandom));
         end else if (kind == 7) begin
            target = (song_step + 2 + $urandom_range(0, 14)) % STEPS_DEFAULT;
            w      = aimed_position(target, num, den, spot, hint);
         end else begin
            w         = req_type'(REQ_W'({$urandom, $urandom, $urandom}));
            w.command = CMD_POSITION;
         end
         offer_word(w);
      end
   endtask

   initial begin : stimulus
      req_type w;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // grid contents for the first steps, both ends of the step range
      send_word(grid_word(4'd1, 8'hFF));
      send_word(grid_word(4'd2, 8'h00));
      send_word(grid_word(4'd3, 8'h80));
      send_word(grid_word(4'd4, 8'h01));
      send_word(grid_word(4'd15, 8'h55));
      send_word(grid_word(4'd0, 8'hAA));
      // dropped positions: invalid playhead, zero denominator, zero numerator, short bar
      w = aimed_position(1, 5'd4, 5'd4, AT_ANY, '1);
      w.playhead_valid = 1'b0;
      send_word(w);
      w = aimed_position(1, 5'd4, 5'd4, AT_ANY, '0);
      w.sig_denominator = 5'd0;
      send_word(w);
      w = aimed_position(1, 5'd4, 5'd4, AT_ANY, '0);
      w.sig_numerator = 5'd0;
      send_word(w);
      w = aimed_position(1, 5'd4, 5'd4, AT_ANY, '0);
      w.sig_numerator   = 5'd3;
      w.sig_denominator = 5'd16;
      send_word(w);
      // step that is not the next one
      send_word(aimed_position(5, 5'd4, 5'd4, AT_ANY, '0));
      // playhead walks steps one to four with odd signatures and range extremes
      send_word(aimed_position(1, 5'd16, 5'd3, AT_LOW, '0));
      send_word(aimed_position(2, 5'd31, 5'd31, AT_HIGH, '1));
      send_word(aimed_position(3, 5'd4, 5'd1, AT_LOW, {16'($urandom), $urandom}));
      send_word(aimed_position(4, 5'd16, 5'd16, AT_HIGH, '0));
      song_step = 4;

      // register settings: low corner, note wrap with zero velocity, top corner, random
      settle();
      write_registers(4'd0, 7'd0, 7'd1);
      random_phase(PHASE_WORDS);
      settle();
      write_registers(4'd15, 7'd127, 7'd0);
      random_phase(PHASE_WORDS);
      settle();
      write_registers(4'd15, 7'd120, 7'd127);
      random_phase(PHASE_WORDS);
      repeat (2) begin
         settle();
         write_registers(CHAN_W'($urandom), NOTE_W'($urandom), NOTE_W'($urandom));
         random_phase(PHASE_WORDS);
      end
      settle();

      if (mismatch_count == 0 && words_due == 0)
         $display("[drum_step_sequencer] OK");
      else
         $display("[drum_step_sequencer] ERROR");
      $finish;
   end

endmodule
